@@ hdl/bb3_pkg.sv @@
// Shared constants, types and a helper function for the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = 16;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int PEND_W      = 24;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic             drain;
        logic [PIX_W-1:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [ROW_W-1:0] height;
    } geom_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PUSH,
        BK_SUM,
        BK_DIV
    } back_state_t;

    // Rounded-up reciprocal of the neighbour count, scaled by 2^RECIP_SHIFT.
    // Exact for every sum that nine 8-bit values can give.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/bb3_front.sv @@
// Input side: takes transfers, classifies pixels and drain ticks, and queues them.
module bb3_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // in_red, in_green, in_blue
    input  logic                  s_tuser,   // mode
    input  bb3_pkg::back_ctrl_t   back_ctrl,
    output logic                  q_valid,
    output bb3_pkg::cmd_t         q_cmd
);

    bb3_pkg::cmd_t                  q_mem_reg [bb3_pkg::Q_DEPTH];
    logic [bb3_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bb3_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bb3_pkg::Q_PTR_W:0]      count_reg, count_next;
    logic                           push, pop;
    bb3_pkg::cmd_t                  in_cmd;

    assign s_tready = (count_reg != (bb3_pkg::Q_PTR_W + 1)'(bb3_pkg::Q_DEPTH))
                      && !back_ctrl.clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = back_ctrl.pop && q_valid;
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    // A drain tick carries a black dummy pixel into the line stores.
    always_comb begin
        in_cmd.drain = (s_tuser == bb3_pkg::MODE_DRAIN);
        in_cmd.pixel = in_cmd.drain ? '0 : s_tdata;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hdl/bb3_back.sv @@
// Processing side: line stores, 3x3 window, neighbourhood mean and result register.
module bb3_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bb3_pkg::geom_t        geom,
    input  logic                  q_valid,
    input  bb3_pkg::cmd_t         q_cmd,
    output bb3_pkg::back_ctrl_t   back_ctrl,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // out_red, out_green, out_blue
    output logic                  m_tlast    // frame_end
);

    bb3_pkg::back_state_t           state_reg, state_next;
    logic [bb3_pkg::COL_W-1:0]      clr_idx_reg, clr_idx_next;
    bb3_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [bb3_pkg::COL_W-1:0]      in_col_reg, in_col_next;
    logic [bb3_pkg::ROW_W-1:0]      in_row_reg, in_row_next;
    logic [bb3_pkg::COL_W-1:0]      out_col_reg, out_col_next;
    logic [bb3_pkg::ROW_W-1:0]      out_row_reg, out_row_next;
    logic [bb3_pkg::PEND_W-1:0]     pend_reg, pend_next;
    logic [bb3_pkg::PIX_W-1:0]      win_reg [3][3];
    logic [bb3_pkg::PIX_W-1:0]      win_next [3][3];
    logic [2:0]                     cv_reg, cv_next;
    logic [bb3_pkg::SUM_W-1:0]      sum_reg [3];
    logic [bb3_pkg::SUM_W-1:0]      sum_next [3];
    logic [bb3_pkg::RECIP_W-1:0]    recip_reg, recip_next;
    logic                           fend_reg, fend_next;
    logic [bb3_pkg::PIX_W-1:0]      m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;
    logic                           m_valid_reg, m_valid_next;

    // Line stores; the middle entry carries a valid bit above the pixel.
    logic [bb3_pkg::PIX_W-1:0]      upper_mem [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W:0]        middle_mem [bb3_pkg::MAX_WIDTH];
    logic [bb3_pkg::PIX_W-1:0]      up_rd_reg;
    logic [bb3_pkg::PIX_W:0]        md_rd_reg;
    logic                           mem_we;
    logic [bb3_pkg::COL_W-1:0]      mem_addr;
    logic [bb3_pkg::PIX_W-1:0]      up_wd;
    logic [bb3_pkg::PIX_W:0]        md_wd;

    logic [2:0]                     inc_c, inc_r;
    logic [1:0]                     ncols, nrows;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Edge exclusions for the output position.
    always_comb begin
        inc_c[0] = (out_col_reg != '0);
        inc_c[1] = 1'b1;
        inc_c[2] = ((bb3_pkg::WID_W'(out_col_reg) + 1'b1) < geom.width);
        inc_r[0] = (out_row_reg != '0);
        inc_r[1] = 1'b1;
        inc_r[2] = (({1'b0, out_row_reg} + 1'b1) < {1'b0, geom.height});
        ncols    = 2'd1 + {1'b0, inc_c[0]} + {1'b0, inc_c[2]};
        nrows    = 2'd1 + {1'b0, inc_r[0]} + {1'b0, inc_r[2]};
    end

    always_comb begin
        logic [bb3_pkg::PROD_W-1:0] prod;
        logic [bb3_pkg::PEND_W-1:0] pend_dec;

        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        cmd_next     = cmd_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        win_next     = win_reg;
        cv_next      = cv_reg;
        sum_next     = sum_reg;
        recip_next   = recip_reg;
        fend_next    = fend_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        back_ctrl.pop      = 1'b0;
        back_ctrl.clearing = (state_reg == bb3_pkg::BK_CLEAR);
        mem_we   = 1'b0;
        mem_addr = in_col_reg;
        up_wd    = md_rd_reg[bb3_pkg::PIX_W-1:0];
        md_wd    = {!cmd_reg.drain, cmd_reg.pixel};
        prod     = '0;
        pend_dec = pend_reg;

        case (state_reg)
            bb3_pkg::BK_CLEAR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_idx_reg;
                up_wd        = '0;
                md_wd        = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == bb3_pkg::COL_W'(bb3_pkg::MAX_WIDTH - 1)) begin
                    state_next = bb3_pkg::BK_IDLE;
                end
            end
            bb3_pkg::BK_IDLE: begin
                // The line stores are read at the input column here; data is ready next cycle.
                if (q_valid) begin
                    back_ctrl.pop = 1'b1;
                    cmd_next      = q_cmd;
                    if (!(q_cmd.drain && pend_reg == '0)) begin
                        if (!q_cmd.drain && pend_reg != '1) begin
                            pend_next = pend_reg + 1'b1;
                        end
                        state_next = bb3_pkg::BK_PUSH;
                    end
                end
            end
            bb3_pkg::BK_PUSH: begin
                mem_we      = 1'b1;
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2][0] = up_rd_reg;
                win_next[2][1] = md_rd_reg[bb3_pkg::PIX_W-1:0];
                win_next[2][2] = cmd_reg.pixel;
                cv_next     = {md_rd_reg[bb3_pkg::PIX_W], cv_reg[2:1]};
                if ((bb3_pkg::WID_W'(in_col_reg) + 1'b1) >= geom.width) begin
                    in_col_next = '0;
                    if (({1'b0, in_row_reg} + 1'b1) >= {1'b0, geom.height}) begin
                        in_row_next = '0;
                    end else begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end else begin
                    in_col_next = in_col_reg + 1'b1;
                end
                // The column now entering the centre decides whether a result leaves.
                if (cv_reg[2]) begin
                    state_next = bb3_pkg::BK_SUM;
                end else begin
                    state_next = bb3_pkg::BK_IDLE;
                end
            end
            bb3_pkg::BK_SUM: begin
                for (int k = 0; k < 3; k++) begin
                    sum_next[k] = '0;
                    for (int c = 0; c < 3; c++) begin
                        for (int r = 0; r < 3; r++) begin
                            if (inc_c[c] && inc_r[r]) begin
                                sum_next[k] = sum_next[k]
                                    + bb3_pkg::SUM_W'(win_reg[c][r][bb3_pkg::CH_W*k +: bb3_pkg::CH_W]);
                            end
                        end
                    end
                end
                recip_next = bb3_pkg::recip(bb3_pkg::CNT_W'(ncols * nrows));
                fend_next  = !inc_c[2] && !inc_r[2];
                state_next = bb3_pkg::BK_DIV;
            end
            bb3_pkg::BK_DIV: begin
                if (!m_valid_reg || m_tready) begin
                    for (int k = 0; k < 3; k++) begin
                        prod = bb3_pkg::PROD_W'(sum_reg[k]) * bb3_pkg::PROD_W'(recip_reg);
                        m_data_next[bb3_pkg::CH_W*k +: bb3_pkg::CH_W] =
                            prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CH_W];
                    end
                    m_last_next  = fend_reg;
                    m_valid_next = 1'b1;
                    if (!inc_c[2]) begin
                        out_col_next = '0;
                        if (!inc_r[2]) begin
                            out_row_next = '0;
                        end else begin
                            out_row_next = out_row_reg + 1'b1;
                        end
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    if (pend_reg != '0) begin
                        pend_dec = pend_reg - 1'b1;
                    end
                    pend_next = pend_dec;
                    // Once a drain has emptied the pipeline the next image starts afresh.
                    if (cmd_reg.drain && pend_dec == '0) begin
                        in_col_next = '0;
                        in_row_next = '0;
                    end
                    state_next = bb3_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = bb3_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bb3_pkg::BK_CLEAR;
            clr_idx_reg <= '0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            cv_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[c][r] <= '0;
                end
            end
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            cv_reg      <= cv_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        sum_reg    <= sum_next;
        recip_reg  <= recip_next;
        fend_reg   <= fend_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            upper_mem[mem_addr]  <= up_wd;
            middle_mem[mem_addr] <= md_wd;
        end
        up_rd_reg <= upper_mem[mem_addr];
        md_rd_reg <= middle_mem[mem_addr];
    end

endmodule

@@ hdl/box_blur_3x3_rgb_top.sv @@
// Top level of the 3x3 RGB box blur: configuration registers, input queue and core.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tdata pixel, s_tuser mode
//   m_        out        m_tvalid / m_tready  m_tdata blurred pixel, m_tlast frame_end
//   cfg_      in         cfg_we               cfg_addr index, cfg_wdata value
//
// An item passes the idle and push states, plus sum and divide if it gives a result, divide
// waiting while the output stalls; a drain tick with nothing pending stays in idle. The core
// reads, then writes, one line-store port per item; the mean is a sum step then a reciprocal
// multiply. After reset the core clears both line stores, one entry a cycle, with s_tready
// low meanwhile. A four-entry queue lets input transfers continue while a result waits.
module box_blur_3x3_rgb_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast,   // frame_end
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [bb3_pkg::CFG_WIDTH_W-1:0] width_cfg_reg;
    logic [bb3_pkg::ROW_W-1:0]       height_cfg_reg;
    bb3_pkg::geom_t                  geom;
    bb3_pkg::back_ctrl_t             back_ctrl;
    logic                            q_valid;
    bb3_pkg::cmd_t                   q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= bb3_pkg::CFG_WIDTH_W'(640);
            height_cfg_reg <= bb3_pkg::ROW_W'(480);
        end else if (cfg_we) begin
            case (bb3_pkg::reg_index_t'(cfg_addr))
                bb3_pkg::REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata[bb3_pkg::CFG_WIDTH_W-1:0];
                bb3_pkg::REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Zero acts as one, and widths beyond the line stores are clamped.
    always_comb begin
        if (width_cfg_reg == '0) begin
            geom.width = bb3_pkg::WID_W'(1);
        end else if (32'(width_cfg_reg) > 32'(bb3_pkg::MAX_WIDTH)) begin
            geom.width = bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH);
        end else begin
            geom.width = bb3_pkg::WID_W'(width_cfg_reg);
        end
        geom.height = (height_cfg_reg == '0) ? bb3_pkg::ROW_W'(1) : height_cfg_reg;
    end

    bb3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .back_ctrl (back_ctrl),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd)
    );

    bb3_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .back_ctrl (back_ctrl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/box_blur_3x3_rgb_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for the 3x3 RGB box blur, with its own blur predictor.
module box_blur_3x3_rgb_top_tb;

    localparam int   QUIET_CYCLES   = 40;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   ITEM_BUDGET    = 500;
    localparam int   MAX_REPORTS    = 20;
    localparam logic MODE_PIXEL     = ~bb3_pkg::MODE_DRAIN;

    typedef struct packed {
        bit [7:0] blue;
        bit [7:0] green;
        bit [7:0] red;
    } rgb_t;

    typedef struct packed {
        bit   frame_end;
        rgb_t colour;
    } blurred_t;

    typedef struct packed {
        bit   drain;
        rgb_t px;
    } stream_item_t;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_MOSTLY,
        RX_CHOKED
    } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = bb3_pkg::REG_IMAGE_WIDTH;
    logic [15:0] cfg_wdata = '0;

    box_blur_3x3_rgb_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Blur predictor state.
    rgb_t        upper_line  [bb3_pkg::MAX_WIDTH];
    rgb_t        middle_line [bb3_pkg::MAX_WIDTH];
    bit          middle_real [bb3_pkg::MAX_WIDTH];
    rgb_t        win [3][3];
    bit          column_real [3];
    int unsigned in_col, in_row, out_col, out_row, backlog;
    bit [10:0]   width_reg  = 11'd640;
    bit [15:0]   height_reg = 16'd480;

    stream_item_t pixel_q [$];
    blurred_t     blurred_q [$];
    int           in_flight;
    int           items_queued;
    int           mismatches;
    int           idle_cycles;
    bit           s_taken;
    int           burst_left;
    int           gap_left;
    rx_mode_t     stall_mode;
    int           stall_left;

    function automatic int unsigned cur_width();
        if (width_reg == 0) return 1;
        if (width_reg > bb3_pkg::MAX_WIDTH) return bb3_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned cur_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Shifts one column into the window; a result is due when the centre column holds
    // a real pixel, and its position in the image decides which neighbours count.
    function automatic void blur_push(rgb_t px, bit is_pixel);
        int unsigned w, h, slot, c_lo, c_hi, r_lo, r_hi, n;
        int unsigned sum_r, sum_g, sum_b;
        rgb_t        above, mid;
        bit          mid_ok;
        blurred_t    res;
        w = cur_width();
        h = cur_height();
        slot = (in_col < bb3_pkg::MAX_WIDTH) ? in_col : 0;
        above = upper_line[slot];
        mid = middle_line[slot];
        mid_ok = middle_real[slot];
        upper_line[slot] = mid;
        middle_line[slot] = px;
        middle_real[slot] = is_pixel;
        for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) win[c][r] = win[c + 1][r];
            column_real[c] = column_real[c + 1];
        end
        win[2][0] = above;
        win[2][1] = mid;
        win[2][2] = px;
        column_real[2] = mid_ok;
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
        end else begin
            in_col++;
        end
        if (!column_real[1]) return;
        c_lo = (out_col > 0) ? 0 : 1;
        c_hi = (out_col + 1 < w) ? 2 : 1;
        r_lo = (out_row > 0) ? 0 : 1;
        r_hi = (out_row + 1 < h) ? 2 : 1;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        n = 0;
        for (int c = c_lo; c <= c_hi; c++) begin
            for (int r = r_lo; r <= r_hi; r++) begin
                sum_r += win[c][r].red;
                sum_g += win[c][r].green;
                sum_b += win[c][r].blue;
                n++;
            end
        end
        res.colour.red   = 8'(sum_r / n);
        res.colour.green = 8'(sum_g / n);
        res.colour.blue  = 8'(sum_b / n);
        res.frame_end    = (out_row + 1 >= h) && (out_col + 1 >= w);
        blurred_q.push_back(res);
        if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
        if (backlog > 0) backlog--;
    endfunction

    function automatic void blur_accept(bit drain, rgb_t px);
        if (drain != bb3_pkg::MODE_DRAIN) begin
            if (backlog < 24'hFFFFFF) backlog++;
            blur_push(px, 1'b1);
        end else if (backlog != 0) begin
            blur_push('0, 1'b0);
            // Once the last pending result has left, the input side starts a fresh image.
            if (backlog == 0) begin
                in_col = 0;
                in_row = 0;
            end
        end
    endfunction

    function automatic void check_field(string label, logic [7:0] got, bit [7:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h, got %h", $time, label, want, got);
        end
    endfunction

    always @(posedge aclk) begin : observe
        blurred_t want;
        if (aresetn) begin
            s_taken <= s_tvalid && s_tready;
            if (cfg_we) begin
                if (cfg_addr == bb3_pkg::REG_IMAGE_WIDTH) width_reg = cfg_wdata[10:0];
                else height_reg = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                if (blurred_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result %h last %b expected none, got one",
                                 $time, m_tdata, m_tlast);
                end else begin
                    want = blurred_q.pop_front();
                    check_field("out_red", m_tdata[7:0], want.colour.red);
                    check_field("out_green", m_tdata[15:8], want.colour.green);
                    check_field("out_blue", m_tdata[23:16], want.colour.blue);
                    check_field("frame_end", {7'd0, m_tlast}, {7'd0, want.frame_end});
                end
            end
            if (s_tvalid && s_tready) begin
                blur_accept(s_tuser, s_tdata);
                in_flight--;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("box_blur_3x3_rgb_top verification failed");
                $finish;
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge aclk) begin : drive
        stream_item_t item;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                item = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= item.px;
                s_tuser <= item.drain;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stretches of free flow, coin tosses, light and heavy back-pressure.
    always @(negedge aclk) begin : stall
        if (stall_left == 0) begin
            stall_mode = rx_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            RX_FREE:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic rgb_t random_rgb();
        bit [23:0] raw;
        raw = 24'($urandom);
        for (int k = 0; k < 3; k++)
            if ($urandom_range(0, 7) == 0) raw[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return rgb_t'(raw);
    endfunction

    task automatic queue_item(bit drain, rgb_t px);
        pixel_q.push_back(stream_item_t'{drain, px});
        in_flight++;
        items_queued++;
    endtask

    task automatic queue_drains(int unsigned count);
        repeat (count) queue_item(bb3_pkg::MODE_DRAIN, random_rgb());
    endtask

    // Waits until every transfer queued so far has gone and every result caused has come.
    task automatic settle();
        while (in_flight != 0 || blurred_q.size() != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(bb3_pkg::reg_index_t idx, bit [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned wv, int unsigned hv);
        bit [15:0] value;
        settle();
        value = 16'(wv);
        // Bits above the width register are junk and must be dropped.
        if ($urandom_range(0, 3) == 0) value[15:11] = 5'($urandom);
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, value);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 16'(hv));
    endtask

    initial begin : stimulus
        int unsigned wv, hv, w, h, frame, npix, extra;
        bit          pause_mid;
        bit          wide_done;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // A 3 by 3 image gives the divisors four, six and nine, the channel extremes and a frame end.
        set_geometry(3, 3);
        queue_drains(1);
        queue_item(MODE_PIXEL, rgb_t'(24'h000000));
        queue_item(MODE_PIXEL, rgb_t'(24'hFFFFFF));
        queue_item(MODE_PIXEL, rgb_t'(24'hFFFFFF));
        queue_item(MODE_PIXEL, rgb_t'(24'h000000));
        queue_item(MODE_PIXEL, rgb_t'(24'hFF00FF));
        queue_item(MODE_PIXEL, rgb_t'(24'h00FF00));
        queue_item(MODE_PIXEL, rgb_t'(24'hAA55AA));
        queue_item(MODE_PIXEL, rgb_t'(24'h55AA55));
        queue_item(MODE_PIXEL, rgb_t'(24'hFFFFFF));
        queue_drains(2);
        queue_item(MODE_PIXEL, rgb_t'(24'hFFFFFF));
        queue_drains(5);

        wide_done = 1'b0;
        while (items_queued < ITEM_BUDGET) begin
            case ($urandom_range(0, 19))
                14:      begin wv = 0;                        hv = $urandom_range(1, 4); end
                15:      begin wv = $urandom_range(1, 4);     hv = 0;                    end
                16:      begin wv = $urandom_range(1, 3);     hv = 65535;                end
                // A width at or above the line-store size needs a long flush, so it is tried only once.
                17:      begin
                    wv = wide_done ? $urandom_range(1, 6) : $urandom_range(1024, 2047);
                    hv = $urandom_range(0, 2);
                    wide_done = 1'b1;
                end
                18:      begin wv = $urandom_range(7, 40);    hv = $urandom_range(1, 3); end
                19:      begin wv = 1;                        hv = 1;                    end
                default: begin wv = $urandom_range(1, 6);     hv = $urandom_range(1, 5); end
            endcase
            set_geometry(wv, hv);
            w = cur_width();
            h = cur_height();
            frame = w * h;
            // Mostly whole images; a partial one leaves the output position mid-image.
            if (frame <= 64 && $urandom_range(0, 4) != 0) npix = frame * $urandom_range(1, 2);
            else npix = $urandom_range(1, (frame < 64) ? frame : 64);
            pause_mid = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < npix; i++) begin
                if (pause_mid && i == npix / 2) settle();
                if ($urandom_range(0, 19) == 0) queue_drains(1);
                queue_item(MODE_PIXEL, random_rgb());
            end
            // Now and then new pixels arrive while the flush is still going on.
            if ($urandom_range(0, 2) == 0) begin
                queue_drains($urandom_range(1, (w < 8) ? w : 8));
                extra = $urandom_range(1, 3);
                repeat (extra) queue_item(MODE_PIXEL, random_rgb());
            end
            queue_drains(w + 1 + $urandom_range(0, 2));
        end

        settle();
        if (mismatches == 0) begin
            $display("box_blur_3x3_rgb_top verification clean");
        end else begin
            $display("box_blur_3x3_rgb_top verification failed");
        end
        $finish;
    end

endmodule
